### hdl/assert_macros.svh
// Assertion macros shared by the projection marker locator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define PML_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define PML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pml_pkg.sv
// Package for the projection marker locator: widths, codes, beat types.
// No dependencies; imported by every pml module and the top level.
`timescale 1ns / 1ps

package pml_pkg;

  // Frame limits; only the reset value of the bright box follows from them
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COORD_W    = 11;
  localparam int LEVEL_W    = 8;
  localparam int COUNT_W    = 21;
  localparam int SUM_W      = 31;
  localparam int RECORD_W   = 3;
  localparam int LUMA_W     = 22;
  localparam int NUM_COLORS = 5;
  localparam int COLOR_W    = 3;
  localparam int QUEUE_DEPTH = 4;

  // Inset = max(2, extent / 100), division by reciprocal multiply
  localparam int INSET_W     = 5;
  localparam int INSET_MUL_W = 13;
  localparam int PROD_W      = COORD_W + INSET_MUL_W;
  localparam int INSET_SHIFT = 19;
  localparam logic [INSET_MUL_W-1:0] INSET_MUL = 13'd5243;
  localparam logic [INSET_W-1:0]     INSET_MIN = 5'd2;
  localparam int BOUND_W = COORD_W + 2;

  // Luma weights, scaled by 10000
  localparam int LUMA_SCALE_INT = 10000;
  localparam logic [LUMA_W-1:0] LUMA_R     = 22'd2126;
  localparam logic [LUMA_W-1:0] LUMA_G     = 22'd7152;
  localparam logic [LUMA_W-1:0] LUMA_B     = 22'd722;
  localparam logic [LUMA_W-1:0] LUMA_SCALE = 22'd10000;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 21;
  localparam logic [CFG_INDEX_W-1:0] REG_LUMA_MIN  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MIN = 4'd1;
  localparam int LUMA_MIN_RESET_INT = 235;
  localparam logic [LUMA_W-1:0]  LUMA_THRESH_RESET =
    LUMA_W'(LUMA_MIN_RESET_INT * LUMA_SCALE_INT);
  localparam logic [COUNT_W-1:0] COUNT_MIN_RESET = 21'd200;

  // Reset corner of the bright box
  localparam logic [COORD_W-1:0] BOX_MIN_X_INIT = COORD_W'((MAX_WIDTH - 1) % (1 << COORD_W));
  localparam logic [COORD_W-1:0] BOX_MIN_Y_INIT = COORD_W'((MAX_HEIGHT - 1) % (1 << COORD_W));

  // Record codes
  localparam logic [RECORD_W-1:0] REC_SUMMARY = 3'd0;
  localparam logic [RECORD_W-1:0] REC_RED     = 3'd1;
  localparam logic [RECORD_W-1:0] REC_GREEN   = 3'd2;
  localparam logic [RECORD_W-1:0] REC_BLUE    = 3'd3;
  localparam logic [RECORD_W-1:0] REC_YELLOW  = 3'd4;
  localparam logic [RECORD_W-1:0] REC_CYAN    = 3'd5;

  // Colour hit bit positions
  localparam int COL_RED    = 0;
  localparam int COL_GREEN  = 1;
  localparam int COL_BLUE   = 2;
  localparam int COL_YELLOW = 3;
  localparam int COL_CYAN   = 4;

  typedef struct packed {
    logic               pass;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               end_of_pass;
  } pml_pixel_t;

  typedef struct packed {
    logic [RECORD_W-1:0] record;
    logic                area_lit;
    logic [COUNT_W-1:0]  sample_total;
    logic [COUNT_W-1:0]  bright_total;
    logic [COORD_W-1:0]  box_left;
    logic [COORD_W-1:0]  box_top;
    logic [COORD_W-1:0]  box_right;
    logic [COORD_W-1:0]  box_bottom;
    logic [SUM_W-1:0]    sum_x;
    logic [SUM_W-1:0]    sum_y;
    logic                last_record;
  } pml_report_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic                  pass;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic                  bright;
    logic [NUM_COLORS-1:0] hits;
    logic                  end_of_pass;
  } pml_item_t;

endpackage

### hdl/pml_front.sv
// Front end: accepts pixel beats, computes luma and the colour rule hits.
// Depends on pml_pkg; feeds pml_queue.
`timescale 1ns / 1ps

module pml_front import pml_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  pml_pixel_t        pixel,
  input  logic [LUMA_W-1:0] luma_thresh,
  output logic              push,
  output pml_item_t         push_item,
  input  logic              full
);

  localparam logic [8:0] RED_MIN     = 9'd150;
  localparam logic [8:0] RED_MARGIN  = 9'd25;
  localparam logic [7:0] GREEN_MIN   = 8'd120;
  localparam logic [7:0] BLUE_MIN    = 8'd115;
  localparam logic [7:0] YEL_R_MIN   = 8'd145;
  localparam logic [7:0] YEL_G_MIN   = 8'd125;
  localparam logic [7:0] YEL_B_MAX   = 8'd125;
  localparam logic [7:0] YEL_DIFF    = 8'd90;
  localparam logic [7:0] CYAN_GB_MIN = 8'd120;
  localparam logic [7:0] CYAN_R_MAX  = 8'd120;
  localparam logic [7:0] CYAN_DIFF   = 8'd100;

  logic [LEVEL_W-1:0]    r, g, b;
  logic [LUMA_W-1:0]     luma;
  logic [NUM_COLORS-1:0] hits;
  logic [8:0]            r9, g9, b9;
  logic [10:0]           g4, r5, b5, r6;
  logic [11:0]           b10, g11;
  logic [LEVEL_W-1:0]    diff_rg, diff_gb;
  logic                  accept;

  logic                  stage_valid;
  pml_pixel_t            stage_px;
  logic [LUMA_W-1:0]     stage_luma;
  logic [NUM_COLORS-1:0] stage_hits;

  assign r = pixel.red_level;
  assign g = pixel.green_level;
  assign b = pixel.blue_level;

  // Scaled luma, constant multiplies only
  assign luma = LUMA_W'(r) * LUMA_R + LUMA_W'(g) * LUMA_G + LUMA_W'(b) * LUMA_B;

  // Exact integer forms of the colour ratios
  always_comb begin
    r9      = {1'b0, r};
    g9      = {1'b0, g};
    b9      = {1'b0, b};
    g4      = {1'b0, g, 2'b00};
    r5      = 11'(r) * 11'd5;
    b5      = 11'(b) * 11'd5;
    r6      = 11'(r) * 11'd6;
    b10     = 12'(b) * 12'd10;
    g11     = 12'(g) * 12'd11;
    diff_rg = (r > g) ? r - g : g - r;
    diff_gb = (g > b) ? g - b : b - g;
    hits[COL_RED]    = (r9 > RED_MIN) && (r9 > g9 + RED_MARGIN) && (r9 > b9 + RED_MARGIN);
    hits[COL_GREEN]  = (g > GREEN_MIN) && (g4 > r5) && (g4 > b5);
    hits[COL_BLUE]   = (b > BLUE_MIN) && (b5 > r6) && (b10 > g11);
    hits[COL_YELLOW] = (r > YEL_R_MIN) && (g > YEL_G_MIN) && (b < YEL_B_MAX) &&
                       (diff_rg < YEL_DIFF);
    hits[COL_CYAN]   = (g > CYAN_GB_MIN) && (b > CYAN_GB_MIN) && (r < CYAN_R_MAX) &&
                       (diff_gb < CYAN_DIFF);
  end

  // Single stage register ahead of the queue
  assign push        = stage_valid && !full;
  assign pixel_ready = !stage_valid || !full;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_px   <= pixel;
      stage_luma <= luma;
      stage_hits <= hits;
    end
  end

  // Bright test against the registered threshold
  always_comb begin
    push_item.pass        = stage_px.pass;
    push_item.column      = stage_px.column;
    push_item.row         = stage_px.row;
    push_item.bright      = stage_luma > luma_thresh;
    push_item.hits        = stage_hits;
    push_item.end_of_pass = stage_px.end_of_pass;
  end

endmodule

### hdl/pml_queue.sv
// Short queue of classified pixels between front and back end.
// Depends on pml_pkg.
`timescale 1ns / 1ps

module pml_queue import pml_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pml_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pml_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pml_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/pml_back.sv
// Back end: bright box, counters, marker accumulators and report sequencing.
// Depends on pml_pkg; drains pml_queue and drives the report register.
`timescale 1ns / 1ps

module pml_back import pml_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  pml_item_t          head,
  output logic               pop,
  input  logic [COUNT_W-1:0] count_min,
  output logic               report_valid,
  input  logic               report_ready,
  output pml_report_t        report
);

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_FOUND  = 3'd1;
  localparam logic [2:0] ST_INSET  = 3'd2;
  localparam logic [2:0] ST_BOUND  = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [COORD_W-1:0] a);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(a);
    return t[SUM_W] ? '1 : t[SUM_W-1:0];
  endfunction

  function automatic logic [INSET_W-1:0] inset_of(input logic [COORD_W-1:0] d);
    logic [PROD_W-1:0]  p;
    logic [INSET_W-1:0] q;
    p = PROD_W'(d) * PROD_W'(INSET_MUL);
    q = p[INSET_SHIFT +: INSET_W];
    return (q > INSET_MIN) ? q : INSET_MIN;
  endfunction

  logic [2:0]                state;
  logic [COORD_W-1:0]        box_min_x, box_min_y, box_max_x, box_max_y;
  logic [COUNT_W-1:0]        sampled_pixels, bright_pixels;
  logic                      projection_found;
  logic [COORD_W-1:0]        diff_x, diff_y;
  logic [INSET_W-1:0]        inset_x, inset_y;
  logic [COORD_W:0]          lo_x, lo_y;
  logic signed [BOUND_W-1:0] hi_x, hi_y;
  logic                      dirty;
  logic [RECORD_W-1:0]       rec_idx;
  logic [COUNT_W-1:0]        marker_counts [NUM_COLORS];
  logic [SUM_W-1:0]          marker_sums_x [NUM_COLORS];
  logic [SUM_W-1:0]          marker_sums_y [NUM_COLORS];

  logic                      sample, hit_x, hit_y, hit, found_now, load;
  logic [COLOR_W-1:0]        color_idx;
  pml_report_t               rec;

  // Pop unless a marker pixel needs freshly computed window bounds
  assign pop    = head_valid && (state == ST_RUN) && !(head.pass && dirty);
  assign sample = !head.column[0] && !head.row[0];

  // Inset window with stride-2 phase
  assign hit_x = ((COORD_W + 1)'(head.column) >= lo_x) &&
                 ($signed(BOUND_W'(head.column)) <= hi_x) && (head.column[0] == lo_x[0]);
  assign hit_y = ((COORD_W + 1)'(head.row) >= lo_y) &&
                 ($signed(BOUND_W'(head.row)) <= hi_y) && (head.row[0] == lo_y[0]);
  assign hit   = projection_found && hit_x && hit_y;

  assign found_now = bright_pixels > count_min;
  assign load      = (state == ST_REPORT) && (!report_valid || report_ready);
  assign color_idx = COLOR_W'(rec_idx - 1'b1);

  // Record contents for the current report index
  always_comb begin
    rec             = '0;
    rec.record      = rec_idx;
    rec.last_record = (rec_idx == REC_CYAN);
    if (rec_idx == REC_SUMMARY) begin
      rec.area_lit     = projection_found;
      rec.sample_total = sampled_pixels;
      rec.bright_total = bright_pixels;
      rec.box_left     = box_min_x;
      rec.box_top      = box_min_y;
      rec.box_right    = box_max_x;
      rec.box_bottom   = box_max_y;
    end else begin
      rec.sample_total = marker_counts[color_idx];
      rec.sum_x        = marker_sums_x[color_idx];
      rec.sum_y        = marker_sums_y[color_idx];
    end
  end

  // Sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst || (load && rec_idx == REC_CYAN)) begin
      box_min_x        <= BOX_MIN_X_INIT;
      box_min_y        <= BOX_MIN_Y_INIT;
      box_max_x        <= '0;
      box_max_y        <= '0;
      sampled_pixels   <= '0;
      bright_pixels    <= '0;
      projection_found <= 1'b0;
      inset_x          <= '0;
      inset_y          <= '0;
      dirty            <= 1'b0;
      state            <= ST_RUN;
      rec_idx          <= REC_SUMMARY;
      for (int k = 0; k < NUM_COLORS; k++) begin
        marker_counts[k] <= '0;
        marker_sums_x[k] <= '0;
        marker_sums_y[k] <= '0;
      end
    end else begin
      case (state)
        ST_RUN: begin
          if (pop && !head.pass) begin
            // Pass one: counts and bright box
            if (sample) begin
              sampled_pixels <= sat_inc(sampled_pixels);
              if (head.bright) begin
                bright_pixels <= sat_inc(bright_pixels);
                if (head.column < box_min_x) box_min_x <= head.column;
                if (head.row < box_min_y) box_min_y <= head.row;
                if (head.column > box_max_x) box_max_x <= head.column;
                if (head.row > box_max_y) box_max_y <= head.row;
                if (projection_found) dirty <= 1'b1;
              end
            end
            if (head.end_of_pass) begin
              state <= ST_FOUND;
            end
          end else if (pop) begin
            // Pass two: marker accumulation
            for (int k = 0; k < NUM_COLORS; k++) begin
              if (hit && head.hits[k]) begin
                marker_counts[k] <= sat_inc(marker_counts[k]);
                marker_sums_x[k] <= sat_add(marker_sums_x[k], head.column);
                marker_sums_y[k] <= sat_add(marker_sums_y[k], head.row);
              end
            end
            if (head.end_of_pass) begin
              state <= ST_REPORT;
            end
          end else if (head_valid && head.pass && dirty) begin
            state <= ST_BOUND;
          end
        end
        ST_FOUND: begin
          projection_found <= found_now;
          if (found_now) begin
            diff_x <= (box_max_x >= box_min_x) ? box_max_x - box_min_x : '0;
            diff_y <= (box_max_y >= box_min_y) ? box_max_y - box_min_y : '0;
            state  <= ST_INSET;
          end else begin
            box_min_x <= '0;
            box_min_y <= '0;
            box_max_x <= '0;
            box_max_y <= '0;
            inset_x   <= '0;
            inset_y   <= '0;
            state     <= ST_RUN;
          end
        end
        ST_INSET: begin
          inset_x <= inset_of(diff_x);
          inset_y <= inset_of(diff_y);
          state   <= ST_BOUND;
        end
        ST_BOUND: begin
          lo_x  <= (COORD_W + 1)'(box_min_x) + (COORD_W + 1)'(inset_x);
          lo_y  <= (COORD_W + 1)'(box_min_y) + (COORD_W + 1)'(inset_y);
          hi_x  <= BOUND_W'(box_max_x) - BOUND_W'(inset_x);
          hi_y  <= BOUND_W'(box_max_y) - BOUND_W'(inset_y);
          dirty <= 1'b0;
          state <= ST_RUN;
        end
        ST_REPORT: begin
          if (load) begin
            rec_idx <= rec_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (load) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report <= rec;
    end
  end

endmodule

### hdl/projection_marker_locator.sv
// Projection marker locator. Takes one pixel beat per clock in both passes;
// the front end registers luma and colour tests, a four-entry queue decouples
// it from the back end, which updates the bright box, counters and marker sums
// one pixel per clock. At the end of pass one the back end pauses for the
// present test, inset multiply and window bounds when a projection is found,
// and for the present test alone when not; a marker pixel that follows a
// bright-box change after pass one waits for new bounds, and the end of pass
// two brings the report beats (summary, then red, green, blue, yellow, cyan,
// the last flagged). The queue absorbs these gaps, so input stalls only when
// it fills. A pixel passes the front-end stage and the queue on its way to the
// back end; the summary beat is registered from the report state once the
// report register is free. No clearing pass is needed after reset.
// Depends on pml_pkg, pml_front, pml_queue, pml_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module projection_marker_locator import pml_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pml_pixel_t             pixel,
  output logic                   report_valid,
  input  logic                   report_ready,
  output pml_report_t            report,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LUMA_W-1:0]  luma_thresh;
  logic [COUNT_W-1:0] count_min;
  logic               push, full, pop, head_valid;
  pml_item_t          push_item, head;

  // Configuration registers; luma limit is kept pre-scaled by 10000
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_thresh <= LUMA_THRESH_RESET;
      count_min   <= COUNT_MIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LUMA_MIN:  luma_thresh <= LUMA_W'(cfg_data[LEVEL_W-1:0]) * LUMA_SCALE;
        REG_COUNT_MIN: count_min   <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pml_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .luma_thresh (luma_thresh),
    .push        (push),
    .push_item   (push_item),
    .full        (full)
  );

  pml_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pml_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .count_min    (count_min),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  // Checks
  `PML_ASSERT_SAME(a_last_is_cyan, clk, rst, report_valid && report.last_record, report.record == REC_CYAN, "last_record on a non-cyan beat")
  `PML_ASSERT_NEXT(a_hold_stable, clk, rst, report_valid && !report_ready, report_valid && $stable(report), "report beat changed while stalled")
  `PML_ASSERT_SAME(a_marker_clean, clk, rst, report_valid && report.record != REC_SUMMARY, !report.area_lit && report.bright_total == '0 && report.box_right == '0, "marker beat carries summary fields")
  `PML_ASSERT_NEXT(a_run_restarts, clk, rst, report_valid && report_ready && report.last_record, !report_valid || report.record == REC_SUMMARY, "report run did not restart at summary")

endmodule

### verif/tb.sv
// Self-checking bench for projection_marker_locator: two-pass frames in, report beats out.
// Depends on pml_pkg for the beat types and codes; the predictor lives in marker_tally.
`timescale 1ns / 1ps

module tb import pml_pkg::*; ();

  localparam int COUNT_LIMIT  = (1 << COUNT_W) - 1;
  localparam int SUM_LIMIT    = 32'h7FFF_FFFF;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES  = 150;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd9;
  localparam logic [23:0] WHITE = 24'hFFFFFF;
  localparam logic [23:0] BLACK = 24'h000000;

  typedef enum {TINT_RED, TINT_GREEN, TINT_BLUE, TINT_YELLOW, TINT_CYAN, TINT_WHITE,
                TINT_ANY} tint_e;

  // Predicts report beats from accepted pixel beats and checks them in order
  class marker_tally;
    int luma_floor, bright_needed;
    int min_x, min_y, max_x, max_y;
    int samples, brights;
    bit found;
    int pad_x, pad_y;
    int hit_count[NUM_COLORS];
    int hit_sum_x[NUM_COLORS];
    int hit_sum_y[NUM_COLORS];
    logic [RECORD_W-1:0] marker_code[NUM_COLORS];
    pml_report_t due_reports[$];
    int mismatches;
    int beats_seen;

    function new();
      luma_floor = LUMA_MIN_RESET_INT;
      bright_needed = COUNT_MIN_RESET;
      marker_code[COL_RED]    = REC_RED;
      marker_code[COL_GREEN]  = REC_GREEN;
      marker_code[COL_BLUE]   = REC_BLUE;
      marker_code[COL_YELLOW] = REC_YELLOW;
      marker_code[COL_CYAN]   = REC_CYAN;
      mismatches = 0;
      beats_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      min_x = BOX_MIN_X_INIT;
      min_y = BOX_MIN_Y_INIT;
      max_x = 0;
      max_y = 0;
      samples = 0;
      brights = 0;
      found = 1'b0;
      pad_x = 0;
      pad_y = 0;
      for (int k = 0; k < NUM_COLORS; k++) begin
        hit_count[k] = 0;
        hit_sum_x[k] = 0;
        hit_sum_y[k] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LUMA_MIN) begin
        luma_floor = data[LEVEL_W-1:0];
      end else if (idx == REG_COUNT_MIN) begin
        bright_needed = data[COUNT_W-1:0];
      end
    endfunction

    function int bump(int v);
      return (v < COUNT_LIMIT) ? v + 1 : COUNT_LIMIT;
    endfunction

    function int sum_in(int s, int a);
      return (SUM_LIMIT - s >= a) ? s + a : SUM_LIMIT;
    endfunction

    function int inset(int lo, int hi);
      int d;
      d = (hi >= lo) ? (hi - lo) / 100 : 0;
      return (d > 2) ? d : 2;
    endfunction

    // Inside the shrunk box and on the stride-2 grid from its near edge
    function bit on_grid(int c, int lo_edge, int hi_edge, int pad);
      int lo, hi;
      lo = lo_edge + pad;
      hi = hi_edge - pad;
      if (c < lo || c > hi) return 1'b0;
      return ((c - lo) % 2) == 0;
    endfunction

    function int gap(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void add_hit(int k, int x, int y);
      hit_count[k] = bump(hit_count[k]);
      hit_sum_x[k] = sum_in(hit_sum_x[k], x);
      hit_sum_y[k] = sum_in(hit_sum_y[k], y);
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void note_pixel(pml_pixel_t p);
      int x, y, r, g, b, luma;
      pml_report_t rec;
      x = p.column;
      y = p.row;
      r = p.red_level;
      g = p.green_level;
      b = p.blue_level;
      // bright box scan
      if (p.pass == 1'b0) begin
        if (p.column[0] == 1'b0 && p.row[0] == 1'b0) begin
          luma = 2126 * r + 7152 * g + 722 * b;
          samples = bump(samples);
          if (luma > luma_floor * 10000) begin
            brights = bump(brights);
            if (x < min_x) min_x = x;
            if (y < min_y) min_y = y;
            if (x > max_x) max_x = x;
            if (y > max_y) max_y = y;
          end
        end
        if (p.end_of_pass) begin
          found = (brights > bright_needed);
          if (!found) begin
            min_x = 0;
            min_y = 0;
            max_x = 0;
            max_y = 0;
            pad_x = 0;
            pad_y = 0;
          end else begin
            pad_x = inset(min_x, max_x);
            pad_y = inset(min_y, max_y);
          end
        end
        return;
      end
      // marker scan
      if (found && on_grid(x, min_x, max_x, pad_x) && on_grid(y, min_y, max_y, pad_y)) begin
        if (r > 150 && r > g + 25 && r > b + 25) add_hit(COL_RED, x, y);
        if (g > 120 && 4 * g > 5 * r && 4 * g > 5 * b) add_hit(COL_GREEN, x, y);
        if (b > 115 && 5 * b > 6 * r && 10 * b > 11 * g) add_hit(COL_BLUE, x, y);
        if (r > 145 && g > 125 && b < 125 && gap(r, g) < 90) add_hit(COL_YELLOW, x, y);
        if (g > 120 && b > 120 && r < 120 && gap(g, b) < 100) add_hit(COL_CYAN, x, y);
      end
      if (p.end_of_pass) begin
        rec = '0;
        rec.record = REC_SUMMARY;
        rec.area_lit = found;
        rec.sample_total = samples[COUNT_W-1:0];
        rec.bright_total = brights[COUNT_W-1:0];
        rec.box_left = min_x[COORD_W-1:0];
        rec.box_top = min_y[COORD_W-1:0];
        rec.box_right = max_x[COORD_W-1:0];
        rec.box_bottom = max_y[COORD_W-1:0];
        due_reports = {due_reports, rec};
        for (int k = 0; k < NUM_COLORS; k++) begin
          rec = '0;
          rec.record = marker_code[k];
          rec.sample_total = hit_count[k][COUNT_W-1:0];
          rec.sum_x = hit_sum_x[k][SUM_W-1:0];
          rec.sum_y = hit_sum_y[k][SUM_W-1:0];
          rec.last_record = (k == COL_CYAN);
          due_reports = {due_reports, rec};
        end
        clear_frame();
      end
    endfunction

    task flag_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
      $display("mismatch on report beat %0d, %s: got %0d, expected %0d",
               beats_seen, what, got_v, want_v);
      mismatches++;
    endtask

    task check_report(pml_report_t got);
      pml_report_t want;
      beats_seen++;
      if (due_reports.size() == 0) begin
        flag_mismatch("beat with nothing due, record", got.record, 0);
        return;
      end
      want = due_reports.pop_front();
      if (got.record !== want.record) flag_mismatch("record", got.record, want.record);
      if (got.area_lit !== want.area_lit)
        flag_mismatch("area_lit", got.area_lit, want.area_lit);
      if (got.sample_total !== want.sample_total)
        flag_mismatch("sample_total", got.sample_total, want.sample_total);
      if (got.bright_total !== want.bright_total)
        flag_mismatch("bright_total", got.bright_total, want.bright_total);
      if (got.box_left !== want.box_left) flag_mismatch("box_left", got.box_left, want.box_left);
      if (got.box_top !== want.box_top) flag_mismatch("box_top", got.box_top, want.box_top);
      if (got.box_right !== want.box_right)
        flag_mismatch("box_right", got.box_right, want.box_right);
      if (got.box_bottom !== want.box_bottom)
        flag_mismatch("box_bottom", got.box_bottom, want.box_bottom);
      if (got.sum_x !== want.sum_x) flag_mismatch("sum_x", got.sum_x, want.sum_x);
      if (got.sum_y !== want.sum_y) flag_mismatch("sum_y", got.sum_y, want.sum_y);
      if (got.last_record !== want.last_record)
        flag_mismatch("last_record", got.last_record, want.last_record);
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_ready;
  pml_pixel_t             pixel;
  logic                   report_valid;
  logic                   report_ready;
  pml_report_t            report;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  marker_tally sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;

  projection_marker_locator dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // Monitor: every beat is taken at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (report_valid && report_ready) sb.check_report(report);
      if (pixel_valid && pixel_ready) sb.note_pixel(pixel);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Report side: random stalls, plus one long hold-off on request
  initial begin
    report_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ready <= 1'b0;
      end else begin
        report_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] level(input int lo, input int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic pml_pixel_t make_pixel(input bit scan, input int x, input int y,
                                            input logic [23:0] rgb, input bit last);
    pml_pixel_t p;
    p.pass = scan;
    p.column = x[COORD_W-1:0];
    p.row = y[COORD_W-1:0];
    p.red_level = rgb[23:16];
    p.green_level = rgb[15:8];
    p.blue_level = rgb[7:0];
    p.end_of_pass = last;
    return p;
  endfunction

  // Colour leaning toward one marker rule, or anything at all
  function automatic logic [23:0] marker_colour();
    tint_e tint;
    tint = tint_e'($urandom_range(0, 6));
    case (tint)
      TINT_RED:    return {level(160, 255), level(0, 100), level(0, 100)};
      TINT_GREEN:  return {level(0, 100), level(150, 255), level(0, 100)};
      TINT_BLUE:   return {level(0, 100), level(0, 100), level(150, 255)};
      TINT_YELLOW: return {level(150, 230), level(130, 230), level(0, 120)};
      TINT_CYAN:   return {level(0, 110), level(130, 255), level(130, 255)};
      TINT_WHITE:  return {level(200, 255), level(200, 255), level(200, 255)};
      default:     return 24'($urandom);
    endcase
  endfunction

  // A coordinate on the marker grid of one axis, when the grid is not empty
  function automatic int grid_pick(input int lo_edge, input int hi_edge, input int pad);
    int lo, hi;
    lo = lo_edge + pad;
    hi = hi_edge - pad;
    if (hi < lo) return $urandom_range(0, 2047);
    return lo + 2 * $urandom_range(0, (hi - lo) / 2);
  endfunction

  // Entered and left at a falling edge; valid stays up for a following beat
  task automatic send_pixel(input pml_pixel_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    pixel <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every due report, then let the pipeline drain
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One frame: a bright patch for pass one, then marker candidates in pass two
  task automatic run_frame(input int n_first, input int n_second);
    int x0, y0, wx, wy, x, y;
    logic [23:0] rgb;
    bit lit;
    if ($urandom_range(0, 7) == 0) begin
      x0 = 2 * $urandom_range(0, 5);
      y0 = 2 * $urandom_range(0, 5);
      wx = 2046 - x0;
      wy = 2046 - y0;
    end else begin
      x0 = 2 * $urandom_range(0, 870);
      y0 = 2 * $urandom_range(0, 870);
      wx = 2 * $urandom_range(2, 150);
      wy = 2 * $urandom_range(2, 150);
    end
    for (int k = 0; k < n_first; k++) begin
      lit = (k < 2) || ($urandom_range(0, 3) != 0);
      if (k == 0) begin
        x = x0;
        y = y0;
      end else if (k == 1) begin
        x = x0 + wx;
        y = y0 + wy;
      end else if (lit) begin
        x = x0 + 2 * $urandom_range(0, wx / 2);
        y = y0 + 2 * $urandom_range(0, wy / 2);
      end else begin
        x = $urandom_range(0, 2047);
        y = $urandom_range(0, 2047);
      end
      rgb = lit ? {level(220, 255), level(220, 255), level(220, 255)} : 24'($urandom);
      // stray marker beat while the box is still unknown
      if ($urandom_range(0, 19) == 0)
        send_pixel(make_pixel(1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                              marker_colour(), 1'b0));
      send_pixel(make_pixel(1'b0, x, y, rgb, k == n_first - 1));
    end
    // late pass-one beat, after pass one has ended
    if ($urandom_range(0, 3) == 0)
      send_pixel(make_pixel(1'b0, x0 + 2 * $urandom_range(0, wx / 2),
                            y0 + 2 * $urandom_range(0, wy / 2), WHITE, 1'b0));
    for (int k = 0; k < n_second; k++) begin
      if (sb.found && $urandom_range(0, 4) != 0) begin
        x = grid_pick(sb.min_x, sb.max_x, sb.pad_x);
        y = grid_pick(sb.min_y, sb.max_y, sb.pad_y);
      end else begin
        x = $urandom_range(0, 2047);
        y = $urandom_range(0, 2047);
      end
      send_pixel(make_pixel(1'b1, x, y, marker_colour(), k == n_second - 1));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset thresholds, no projection found
    write_reg(REG_LUMA_MIN, 235, 1'b0);
    write_reg(REG_COUNT_MIN, 200, 1'b1);
    send_pixel(make_pixel(1'b1, 100, 100, WHITE, 1'b0));  // marker scan before pass one
    send_pixel(make_pixel(1'b0, 0, 0, WHITE, 1'b0));
    send_pixel(make_pixel(1'b0, 2046, 2046, WHITE, 1'b0));
    send_pixel(make_pixel(1'b0, 2047, 2047, WHITE, 1'b0));  // odd, not sampled
    send_pixel(make_pixel(1'b0, 0, 2047, BLACK, 1'b1));
    send_pixel(make_pixel(1'b1, 2046, 2046, WHITE, 1'b1));
    settle();

    // Directed: projection found, box moved after pass one, each colour rule
    write_reg(REG_COUNT_MIN, 1, 1'b1);
    send_pixel(make_pixel(1'b0, 100, 100, WHITE, 1'b0));
    send_pixel(make_pixel(1'b0, 360, 240, WHITE, 1'b0));
    send_pixel(make_pixel(1'b1, 300, 300, 24'hFF0000, 1'b0));
    send_pixel(make_pixel(1'b0, 2046, 2046, WHITE, 1'b0));
    send_pixel(make_pixel(1'b0, 1, 1, BLACK, 1'b1));
    send_pixel(make_pixel(1'b0, 50, 50, WHITE, 1'b0));
    send_pixel(make_pixel(1'b1, 69, 69, 24'hFF0000, 1'b0));
    send_pixel(make_pixel(1'b1, 71, 71, 24'h00FF00, 1'b0));
    send_pixel(make_pixel(1'b1, 73, 73, 24'h0000FF, 1'b0));
    send_pixel(make_pixel(1'b1, 75, 75, 24'hC8C800, 1'b0));
    send_pixel(make_pixel(1'b1, 77, 77, 24'h00C8C8, 1'b0));
    send_pixel(make_pixel(1'b1, 70, 69, 24'hFF0000, 1'b0));  // off the grid
    send_pixel(make_pixel(1'b0, 3, 5, BLACK, 1'b1));         // second end of pass one
    send_pixel(make_pixel(1'b1, 2027, 2027, 24'h3CC896, 1'b1));  // green and cyan at once
    settle();

    // Steady flow, low count floor
    write_reg(REG_LUMA_MIN, 235, 1'b0);
    write_reg(REG_COUNT_MIN, 3, 1'b1);
    run_frame(6, 4);
    run_frame(6, 4);
    settle();

    // Sender gaps; luma floor of zero written with high junk bits that get masked
    send_idle_pct = 58;
    write_reg(REG_LUMA_MIN, 21'h1FFF00, 1'b0);
    write_reg(REG_COUNT_MIN, 0, 1'b1);
    run_frame(8, 6);
    settle();

    // Receiver stalls; both floors at the top, and a write to no register
    send_idle_pct = 0;
    recv_stall_pct = 58;
    write_reg(REG_LUMA_MIN, 255, 1'b0);
    write_reg(REG_COUNT_MIN, 21'h1FFFFF, 1'b0);
    write_reg(REG_UNUSED, 21'h000005, 1'b1);
    run_frame(8, 6);
    settle();

    // Light idling on both sides
    send_idle_pct = 15;
    recv_stall_pct = 15;
    write_reg(REG_LUMA_MIN, 200, 1'b0);
    write_reg(REG_COUNT_MIN, 4, 1'b1);
    run_frame(6, 4);
    settle();

    // Back-pressure: long report hold-off while short frames keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_LUMA_MIN, 235, 1'b0);
    write_reg(REG_COUNT_MIN, 1, 1'b1);
    hold_request = 1'b1;
    repeat (4) run_frame(3, 2);
    settle();

    // Count floor with only its top bit set
    send_idle_pct = 58;
    recv_stall_pct = 58;
    write_reg(REG_LUMA_MIN, 100, 1'b0);
    write_reg(REG_COUNT_MIN, 1048576, 1'b1);
    run_frame(6, 4);
    settle();

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
